// File: hw/rtl/fcc_pkg.sv
// Shared constants, codes and control types for the cluster chain engine.
`default_nettype none

package fcc_pkg;

    localparam int NUM_CLUSTERS_DEF      = 4096;
    localparam int RESERVED_CLUSTERS_DEF = 10;

    localparam logic [15:0] LINK_FREE   = 16'h0000;
    localparam logic [15:0] LINK_END    = 16'hFFFF;
    localparam logic [15:0] LINK_MEDIA  = 16'hFFFD;
    localparam logic [15:0] LINK_HEADER = 16'hFFFE;

    localparam logic [2:0] OP_FORMAT = 3'd0;
    localparam logic [2:0] OP_ALLOC  = 3'd1;
    localparam logic [2:0] OP_EXTEND = 3'd2;
    localparam logic [2:0] OP_FREE   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // read address select
    localparam logic [1:0] RA_CUR  = 2'd0;
    localparam logic [1:0] RA_PTR  = 2'd1;
    localparam logic [1:0] RA_LINK = 2'd2;

    // write select
    localparam logic [2:0] WS_NONE     = 3'd0;
    localparam logic [2:0] WS_FMT      = 3'd1;
    localparam logic [2:0] WS_CUR_NEW  = 3'd2;
    localparam logic [2:0] WS_NEW_END  = 3'd3;
    localparam logic [2:0] WS_CUR_ZERO = 3'd4;

    typedef struct packed {
        logic       latch;
        logic       sweep_start;
        logic       sweep_step;
        logic       scan_start;
        logic       scan_step;
        logic       new_load;
        logic       walk_adv;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic [2:0] wr_sel;
        logic       res_set;
        logic [1:0] res_status;
        logic       res_new;
        logic       res_link;
        logic       present;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       last;
        logic       in_valid;
        logic       rd_end;
        logic       rd_zero;
        logic       rd_valid;
        logic       scan_hit;
        logic       scan_end;
        logic       sweep_end;
    } t_sts;

    // Formatted value of one table entry.
    function automatic logic [15:0] fcc_fmt_value(input logic [16:0] idx,
                                                  input logic [16:0] rsv);
        logic [15:0] v;
        v = LINK_FREE;
        if (idx < rsv) begin
            if (idx + 17'd1 == rsv) begin
                v = LINK_END;
            end else if (idx == 17'd0) begin
                v = LINK_MEDIA;
            end else begin
                v = LINK_HEADER;
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fcc_ctrl.sv
// Sequencer for the cluster chain engine: operation control and output handshake.
`default_nettype none

module fcc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  wire logic          i_ready,
    input  wire fcc_pkg::t_sts i_sts,
    output fcc_pkg::t_cmd      o_cmd
);
    import fcc_pkg::*;

    localparam logic [2:0] S_SWEEP  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_WRLINK = 3'd5;
    localparam logic [2:0] S_WREND  = 3'd6;
    localparam logic [2:0] S_RESULT = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_walk, n_walk;     // chain free in progress
    logic       r_report, n_report; // sweep came from a format request
    logic       r_out_valid, n_out_valid;
    t_cmd       cmd;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_walk      = r_walk;
        n_report    = r_report;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_SWEEP: begin
                cmd.sweep_step = 1'b1;
                cmd.wr_sel     = WS_FMT;
                if (i_sts.sweep_end) begin
                    if (r_report) begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_OK;
                        n_report       = 1'b0;
                        n_state        = S_RESULT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    cmd.latch = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_sts.op) inside
                    OP_FORMAT: begin
                        cmd.sweep_start = 1'b1;
                        n_report        = 1'b1;
                        n_state         = S_SWEEP;
                    end
                    OP_ALLOC: begin
                        cmd.scan_start = 1'b1;
                        n_state        = S_SCAN;
                    end
                    OP_EXTEND, OP_FREE, OP_READ: begin
                        if (!i_sts.in_valid) begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = ST_BAD;
                            n_state        = S_RESULT;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RA_CUR;
                            n_walk     = (i_sts.op == OP_FREE);
                            n_state    = S_CHECK;
                        end
                    end
                    default: begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_BAD;
                        n_state        = S_RESULT;
                    end
                endcase
            end
            S_CHECK: begin
                if (r_walk) begin
                    // one chain entry per cycle: clear it and fetch its successor
                    if (i_sts.rd_zero) begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_BAD;
                        n_walk         = 1'b0;
                        n_state        = S_RESULT;
                    end else begin
                        cmd.wr_sel = WS_CUR_ZERO;
                        if (i_sts.rd_end || !i_sts.rd_valid) begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = i_sts.rd_end ? ST_OK : ST_BAD;
                            n_walk         = 1'b0;
                            n_state        = S_RESULT;
                        end else begin
                            cmd.walk_adv = 1'b1;
                            cmd.rd_en    = 1'b1;
                            cmd.rd_sel   = RA_LINK;
                        end
                    end
                end else if (i_sts.op == OP_READ) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_link   = 1'b1;
                    cmd.res_status = (i_sts.last ? i_sts.rd_end : i_sts.rd_valid)
                                     ? ST_OK : ST_BAD;
                    n_state        = S_RESULT;
                end else if (!i_sts.rd_end) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_BAD;
                    n_state        = S_RESULT;
                end else begin
                    cmd.scan_start = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = RA_PTR;
                if (i_sts.scan_hit) begin
                    cmd.new_load = 1'b1;
                    n_state      = (i_sts.op == OP_ALLOC) ? S_WREND : S_WRLINK;
                end else if (i_sts.scan_end) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_FULL;
                    n_state        = S_RESULT;
                end
            end
            S_WRLINK: begin
                cmd.wr_sel = WS_CUR_NEW;
                n_state    = S_WREND;
            end
            S_WREND: begin
                cmd.wr_sel     = WS_NEW_END;
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_new    = 1'b1;
                n_state        = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || i_ready) begin
                    cmd.present = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_walk      <= 1'b0;
            r_report    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_walk      <= n_walk;
            r_report    <= n_report;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fcc_dp.sv
// Datapath of the cluster chain engine: link table memory, pointers and result registers.
`default_nettype none

module fcc_dp #(
    parameter int NUM_CLUSTERS      = fcc_pkg::NUM_CLUSTERS_DEF,
    parameter int RESERVED_CLUSTERS = fcc_pkg::RESERVED_CLUSTERS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [2:0]    i_operation,
    input  wire logic [11:0]   i_cluster,
    input  wire logic          i_expect_last,
    input  wire fcc_pkg::t_cmd i_cmd,
    output fcc_pkg::t_sts      o_sts,
    output logic [1:0]         o_status,
    output logic [11:0]        o_new_cluster,
    output logic [15:0]        o_link_value
);
    import fcc_pkg::*;

    localparam int          AW    = $clog2(NUM_CLUSTERS);
    localparam int          PW    = AW + 1;
    localparam logic [16:0] NC17  = 17'(NUM_CLUSTERS);
    localparam logic [16:0] RSV17 = 17'(RESERVED_CLUSTERS);
    localparam logic [PW-1:0] PTR_LAST = PW'(NUM_CLUSTERS - 1);
    localparam logic [PW-1:0] PTR_RSV  = PW'(RESERVED_CLUSTERS);

    logic [15:0]   mem [NUM_CLUSTERS];
    logic [15:0]   r_rdata;

    logic [2:0]    r_op;
    logic [15:0]   r_cluster;
    logic          r_last;
    logic [AW-1:0] r_cur;
    logic [AW-1:0] r_new;
    logic [PW-1:0] r_ptr;
    logic [PW-1:0] r_paddr;
    logic          r_pend;

    logic [1:0]    r_res_status;
    logic          r_res_new;
    logic [15:0]   r_res_link;

    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;
    logic          we;
    logic [15:0]   new16;
    logic [15:0]   cl16;

    function automatic logic is_valid(input logic [15:0] x);
        return (17'(x) >= RSV17) && (17'(x) < NC17);
    endfunction

    assign new16 = 16'(r_new);
    assign cl16  = 16'(i_cluster);

    always_comb begin
        case (i_cmd.rd_sel)
            RA_PTR:  raddr = r_ptr[AW-1:0];
            RA_LINK: raddr = r_rdata[AW-1:0];
            default: raddr = r_cur;
        endcase
    end

    always_comb begin
        we    = 1'b1;
        waddr = r_cur;
        wdata = LINK_FREE;
        case (i_cmd.wr_sel)
            WS_FMT: begin
                waddr = r_ptr[AW-1:0];
                wdata = fcc_fmt_value(17'(r_ptr), RSV17);
            end
            WS_CUR_NEW: begin
                wdata = new16;
            end
            WS_NEW_END: begin
                waddr = r_new;
                wdata = LINK_END;
            end
            WS_CUR_ZERO: begin
                wdata = LINK_FREE;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // table memory; a read of the entry being written returns the new value
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= (we && waddr == raddr) ? wdata : mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_pend <= 1'b0;
        end else begin
            if (i_cmd.sweep_start) begin
                r_ptr <= '0;
            end else if (i_cmd.scan_start) begin
                r_ptr  <= PTR_RSV;
                r_pend <= 1'b0;
            end else if (i_cmd.sweep_step || i_cmd.scan_step) begin
                r_ptr <= r_ptr + PW'(1);
            end
            if (i_cmd.scan_step) begin
                r_pend <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_paddr <= r_ptr;
        end
        if (i_cmd.latch) begin
            r_op      <= i_operation;
            r_cluster <= cl16;
            r_last    <= i_expect_last;
            r_cur     <= cl16[AW-1:0];
        end else if (i_cmd.walk_adv) begin
            r_cur <= r_rdata[AW-1:0];
        end
        if (i_cmd.new_load) begin
            r_new <= r_paddr[AW-1:0];
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_status;
            r_res_new    <= i_cmd.res_new;
            r_res_link   <= i_cmd.res_link ? r_rdata : LINK_FREE;
        end
        if (i_cmd.present) begin
            o_status      <= r_res_status;
            o_new_cluster <= r_res_new ? new16[11:0] : 12'd0;
            o_link_value  <= r_res_link;
        end
    end

    always_comb begin
        o_sts.op        = r_op;
        o_sts.last      = r_last;
        o_sts.in_valid  = is_valid(r_cluster);
        o_sts.rd_end    = (r_rdata == LINK_END);
        o_sts.rd_zero   = (r_rdata == LINK_FREE);
        o_sts.rd_valid  = is_valid(r_rdata);
        o_sts.scan_hit  = r_pend && (r_rdata == LINK_FREE);
        o_sts.scan_end  = r_pend && (r_paddr >= PTR_LAST);
        o_sts.sweep_end = (r_ptr == PTR_LAST);
    end

endmodule

`default_nettype wire

// File: hw/rtl/fat_cluster_chain_engine.sv
// Top level of the cluster chain engine: sequencer plus table datapath.
// Usage:
//   Input channel (i_valid/o_ready) carries one request: i_operation
//   (0 format, 1 allocate, 2 extend, 3 free chain, 4 read link), i_cluster
//   and i_expect_last. Each request yields exactly one result on the output
//   channel (o_valid/i_ready): o_status, o_new_cluster, o_link_value.
//   One request is in flight at a time; o_ready is high only while idle.
//   Work per request, from the input transfer to o_valid:
//     read link: one table read; bad cluster or bad operation: no table access;
//     allocate: a scan from entry RESERVED_CLUSTERS up to the first free index,
//       the table scan reading one entry per cycle;
//     extend: a read of the given cluster, then as allocate plus a link write;
//     free chain: a walk along the chain, one entry cleared per cycle;
//     format: a pass over the whole table, one entry written per cycle.
//   The table memory takes one read and one write per cycle.
//   After reset the table is formatted by a pass over every entry,
//   during which o_ready stays low and no result is produced.
//   A stalled receiver holds the result in the output register; the next
//   request may be taken meanwhile, and its result waits until the
//   pending transfer completes.
`default_nettype none

module fat_cluster_chain_engine #(
    parameter int NUM_CLUSTERS      = fcc_pkg::NUM_CLUSTERS_DEF,
    parameter int RESERVED_CLUSTERS = fcc_pkg::RESERVED_CLUSTERS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_operation,
    input  wire logic [11:0] i_cluster,
    input  wire logic        i_expect_last,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [11:0]      o_new_cluster,
    output logic [15:0]      o_link_value
);
    import fcc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // state machine: request sequencing and output handshake
    fcc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // table memory, scan/walk pointers and result registers
    fcc_dp #(
        .NUM_CLUSTERS      (NUM_CLUSTERS),
        .RESERVED_CLUSTERS (RESERVED_CLUSTERS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_operation   (i_operation),
        .i_cluster     (i_cluster),
        .i_expect_last (i_expect_last),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_status      (o_status),
        .o_new_cluster (o_new_cluster),
        .o_link_value  (o_link_value)
    );

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the cluster chain engine, with a scoreboard class that mirrors the link table.
`timescale 1ns / 100ps

module tb;
    import fcc_pkg::*;

    localparam int NCL = NUM_CLUSTERS_DEF;
    localparam int RSV = RESERVED_CLUSTERS_DEF;

    // Operation codes the block rejects; they only exercise the bad-op path.
    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    // Longest correct quiet stretch is one full-table scan, walk or format
    // plus a short stall; the limit is many times that.
    localparam int QUIET_LIMIT = 50000;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] new_cluster;
        logic [15:0] link_value;
    } t_chain_result;

    // Shadow of the link table plus the queue of results still owed.
    class t_link_board;
        logic [15:0]   tbl [NCL];
        t_chain_result due_results [$];
        int            mismatch_count;
        int            last_taken;

        function new();
            mismatch_count = 0;
            last_taken     = 0;
            wipe();
        endfunction

        function void wipe();
            int i;
            for (i = 0; i < NCL; i++) begin
                if (i >= RSV) begin
                    tbl[i] = LINK_FREE;
                end else if (i + 1 == RSV) begin
                    tbl[i] = LINK_END;
                end else if (i == 0) begin
                    tbl[i] = LINK_MEDIA;
                end else begin
                    tbl[i] = LINK_HEADER;
                end
            end
        endfunction

        function bit in_data_area(int c);
            return c >= RSV && c < NCL;
        endfunction

        // Lowest free data cluster, NCL when the table is full.
        function int lowest_free();
            int i;
            for (i = RSV; i < NCL; i++) begin
                if (tbl[i] == LINK_FREE) begin
                    return i;
                end
            end
            return NCL;
        endfunction

        // Each entry is cleared before its link is followed; a fault
        // leaves the entries already cleared free.
        function logic [1:0] release_chain(int c);
            int k;
            int nxt;
            if (!in_data_area(c) || tbl[c] == LINK_FREE) begin
                return ST_BAD;
            end
            for (k = 0; k <= NCL; k++) begin
                nxt = tbl[c];
                if (nxt == LINK_FREE) begin
                    return ST_BAD;
                end
                tbl[c] = LINK_FREE;
                if (nxt == LINK_END) begin
                    return ST_OK;
                end
                if (!in_data_area(nxt)) begin
                    return ST_BAD;
                end
                c = nxt;
            end
            return ST_BAD;
        endfunction

        function void take_request(logic [2:0] op, logic [11:0] cl, logic last);
            t_chain_result r;
            int            n;
            int            lk;
            r = '0;
            case (op)
                OP_FORMAT: begin
                    wipe();
                end
                OP_ALLOC: begin
                    n = lowest_free();
                    if (n >= NCL) begin
                        r.status = ST_FULL;
                    end else begin
                        tbl[n] = LINK_END;
                        r.new_cluster = n[11:0];
                    end
                end
                OP_EXTEND: begin
                    if (!in_data_area(cl) || tbl[cl] != LINK_END) begin
                        r.status = ST_BAD;
                    end else begin
                        n = lowest_free();
                        if (n >= NCL) begin
                            r.status = ST_FULL;
                        end else begin
                            tbl[cl] = n[15:0];
                            tbl[n]  = LINK_END;
                            r.new_cluster = n[11:0];
                        end
                    end
                end
                OP_FREE: begin
                    r.status = release_chain(cl);
                end
                OP_READ: begin
                    if (!in_data_area(cl)) begin
                        r.status = ST_BAD;
                    end else begin
                        lk = tbl[cl];
                        r.link_value = tbl[cl];
                        if (last) begin
                            if (lk != LINK_END) begin
                                r.status = ST_BAD;
                            end
                        end else if (!in_data_area(lk)) begin
                            r.status = ST_BAD;
                        end
                    end
                end
                default: begin
                    r.status = ST_BAD;
                end
            endcase
            last_taken = r.new_cluster;
            due_results = {due_results, r};
        endfunction

        function void match_result(logic [1:0] st, logic [11:0] nc, logic [15:0] lv);
            t_chain_result e;
            if (due_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: unexpected result status %0d new %0d link %h",
                             $realtime, st, nc, lv);
                end
                return;
            end
            e = due_results.pop_front();
            if (st !== e.status || nc !== e.new_cluster || lv !== e.link_value) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: mismatch exp status %0d new %0d link %h, got %0d %0d %h",
                             $realtime, e.status, e.new_cluster, e.link_value, st, nc, lv);
                end
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [2:0]  i_operation   = OP_FORMAT;
    logic [11:0] i_cluster     = '0;
    logic        i_expect_last = 1'b0;
    logic        i_ready       = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [11:0] o_new_cluster;
    logic [15:0] o_link_value;

    t_link_board board = new;

    int feed_gap_pct    = 0;   // chance per cycle that the request side holds off
    int drain_stall_pct = 0;   // chance per cycle that the result side stalls
    int quiet_cycles    = 0;
    int chain_heads [$];       // first clusters of chains started by allocate

    fat_cluster_chain_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_cluster     (i_cluster),
        .i_expect_last (i_expect_last),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_new_cluster (o_new_cluster),
        .o_link_value  (o_link_value)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Result side: check on every transfer, then pick next cycle's ready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.match_result(o_status, o_new_cluster, o_link_value);
        end
        i_ready <= ($urandom_range(99) >= drain_stall_pct);
    end

    // Watchdog: any transfer on either side restarts the count.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one request and hold it until the transfer. Called in the
    // time step of a rising edge; returns in the step of the accepting edge,
    // so valid is never dropped and raised again within one step.
    task automatic send_request(input logic [2:0] op, input logic [11:0] cl,
                                input logic last);
        while ($urandom_range(99) < feed_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_cluster     <= cl;
        i_expect_last <= last;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        board.take_request(op, cl, last);
    endtask

    // Random cluster that currently holds a link; a random data cluster
    // when the table is empty.
    function automatic int pick_used();
        int start;
        int k;
        int idx;
        start = $urandom_range(NCL - 1, RSV);
        for (k = 0; k < NCL - RSV; k++) begin
            idx = RSV + (start - RSV + k) % (NCL - RSV);
            if (board.tbl[idx] != LINK_FREE) begin
                return idx;
            end
        end
        return start;
    endfunction

    // Follow links to the end marker; stops early on any broken link.
    function automatic int tail_of(int c);
        int k;
        for (k = 0; k < NCL; k++) begin
            if (board.tbl[c] == LINK_END || board.tbl[c] < RSV || board.tbl[c] >= NCL) begin
                return c;
            end
            c = board.tbl[c];
        end
        return c;
    endfunction

    // Mostly well-formed work: allocate, grow chains at their tail, free
    // them from the head, read links with a matching end expectation.
    // The rest formats or hits random clusters, stale heads and rejected opcodes.
    task automatic random_burst(input int count);
        int         k;
        int         pick;
        int         cl;
        int         idx;
        logic [2:0] op;
        logic       last;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            cl   = $urandom_range(NCL - 1);
            last = 1'($urandom_range(1));
            if (pick < 1) begin
                op = OP_FORMAT;
            end else if (pick < 4) begin
                op = OP_SPARE_A + 3'($urandom_range(2));
            end else if (pick < 28) begin
                op = OP_ALLOC;
            end else if (pick < 52) begin
                op = OP_EXTEND;
                if ($urandom_range(3) != 0) begin
                    cl = tail_of(pick_used());
                end
            end else if (pick < 68) begin
                op = OP_FREE;
                if (chain_heads.size() > 0 && $urandom_range(4) != 0) begin
                    idx = $urandom_range(chain_heads.size() - 1);
                    cl  = chain_heads[idx];
                    chain_heads.delete(idx);
                end else if ($urandom_range(1) != 0) begin
                    cl = pick_used();   // often mid-chain: leaves a broken chain
                end
            end else begin
                op = OP_READ;
                if ($urandom_range(4) != 0) begin
                    cl   = pick_used();
                    last = (board.tbl[cl] == LINK_END);
                    if ($urandom_range(4) == 0) begin
                        last = !last;
                    end
                end
            end
            send_request(op, cl[11:0], last);
            if (op == OP_ALLOC && board.last_taken != 0) begin
                chain_heads = {chain_heads, board.last_taken};
            end
            if (op == OP_FORMAT) begin
                chain_heads.delete();
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase 1: light request gaps, heavy result stalls.
        feed_gap_pct    = 13;
        drain_stall_pct = 87;

        // Directed: free cluster read, two chains, extend from non-last,
        // read checks both ways, reserved and top clusters, a mid-chain
        // free that breaks the walk from the head, double free, spare ops, format.
        send_request(OP_READ,   12'd10,  1'b0);
        send_request(OP_ALLOC,  12'hFFF, 1'b1);
        send_request(OP_ALLOC,  12'h000, 1'b0);
        send_request(OP_EXTEND, 12'd10,  1'b0);
        send_request(OP_EXTEND, 12'd10,  1'b1);
        send_request(OP_EXTEND, 12'd12,  1'b0);
        send_request(OP_READ,   12'd10,  1'b0);
        send_request(OP_READ,   12'd13,  1'b1);
        send_request(OP_READ,   12'd13,  1'b0);
        send_request(OP_READ,   12'd12,  1'b1);
        send_request(OP_READ,   12'd9,   1'b1);
        send_request(OP_READ,   12'd0,   1'b0);
        send_request(OP_READ,   12'hFFF, 1'b1);
        send_request(OP_EXTEND, 12'hFFF, 1'b1);
        send_request(OP_EXTEND, 12'd0,   1'b0);
        send_request(OP_FREE,   12'd12,  1'b0);
        send_request(OP_FREE,   12'd10,  1'b1);
        send_request(OP_FREE,   12'd11,  1'b0);
        send_request(OP_FREE,   12'd11,  1'b1);
        send_request(OP_FREE,   12'd5,   1'b0);
        send_request(OP_SPARE_A, 12'hFFF, 1'b1);
        send_request(OP_SPARE_B, 12'h000, 1'b0);
        send_request(OP_SPARE_C, 12'hA5A, 1'b1);
        send_request(OP_ALLOC,  12'h5A5, 1'b0);
        send_request(OP_FORMAT, 12'hFFF, 1'b1);
        send_request(OP_READ,   12'd10,  1'b0);

        random_burst(250);

        // Phase 2: heavy request gaps, light result stalls.
        feed_gap_pct    = 87;
        drain_stall_pct = 13;
        random_burst(250);

        // Phase 3: both sides at full rate.
        feed_gap_pct    = 0;
        drain_stall_pct = 0;
        random_burst(250);

        i_valid <= 1'b0;
        while (board.due_results.size() != 0) begin
            @(posedge i_clk);
        end
        // every request yields a result, so only a short drain is needed
        repeat (16) @(posedge i_clk);

        if (board.mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/fcc_pkg.sv
hw/rtl/fcc_ctrl.sv
hw/rtl/fcc_dp.sv
hw/rtl/fat_cluster_chain_engine.sv
tb/tb.sv
